FILE: rtl/pbs_pkg.sv
// Package for the packed bit stack: operation codes, status codes and state type.
`default_nettype none

package pbs_pkg;

  // Operation requested by one input item.
  typedef enum logic [2:0] {
    ACT_PUSH_BIT  = 3'd0,
    ACT_POP_BIT   = 3'd1,
    ACT_PUSH_BYTE = 3'd2,
    ACT_POP_BYTE  = 3'd3,
    ACT_READ_BIT  = 3'd4,
    ACT_WRITE_BIT = 3'd5
  } action_e;

  // Completion status returned with each result.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_RANGE     = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // Sequencer states, one-hot.
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  // Bit fill of the last chunk that means no partial chunk.
  localparam logic [3:0] FILL_FULL = 4'd8;

endpackage

`default_nettype wire

FILE: rtl/packed_bit_stack_core.sv
// Packed bit stack: bits stored msb first in a chunk memory with an idle/execute sequencer.
// The result strobe is registered: start is taken in the idle state, the sequencer moves to
// the execute state, and done is set from that state. A new operation is taken only in idle,
// after the read of the chunk memory and its read-modify-write back; busy is high in execute.
// Reset: the stack is empty at once (no chunks, no partial chunk); memory is not cleared.
// The receiver cannot stall: done is high for exactly one cycle with each result.
`default_nettype none

module packed_bit_stack_core #(
  parameter int CAPACITY_BYTES = 512
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [2:0]  action_i,
  input  wire logic        bit_value_i,
  input  wire logic [7:0]  byte_value_i,
  input  wire logic [11:0] bit_index_i,
  output logic             done_o,
  output logic             read_bit_o,
  output logic [7:0]       read_byte_o,
  output logic [1:0]       status_o,
  output logic [12:0]      bit_count_o
);

  localparam int AW = (CAPACITY_BYTES > 1) ? $clog2(CAPACITY_BYTES) : 1;
  localparam int CW = $clog2(CAPACITY_BYTES + 1);
  localparam int HW = (CW + 3 > 13) ? CW + 3 : 13;

  // Sequencer and stack bookkeeping.
  pbs_pkg::state_e state_q, state_d;
  logic [CW-1:0]   cc_q, cc_d;
  logic [3:0]      lf_q, lf_d;

  // Operation context captured when a transfer is accepted.
  pbs_pkg::action_e op_q;
  pbs_pkg::status_e stat_q, stat_d;
  logic             bitv_q;
  logic [7:0]       bytev_q;
  logic [3:0]       olf_q;
  logic [2:0]       pos_q, pos_d;
  logic             rmw_q, rmw_d;
  logic [AW-1:0]    rmw_addr_q, rmw_addr_d;

  // Result registers.
  logic             done_q;
  logic             rbit_q;
  logic [7:0]       rbyte_q;
  logic [1:0]       rstat_q;
  logic [12:0]      count_q;

  // Chunk memory with two read ports and one write port.
  logic [7:0]       mem [CAPACITY_BYTES];
  logic [AW-1:0]    raddr_a, raddr_b, waddr;
  logic [7:0]       wdata, rd_a_q, rd_b_q;
  logic             we;

  // Accept-side decode.
  pbs_pkg::action_e act;
  logic             accept;
  logic             aligned;
  logic [CW-1:0]    cc_m1, cc_m2;
  logic [HW-1:0]    held, idx_ext;
  logic [AW-1:0]    idx_addr;
  logic             alloc_we;
  logic [7:0]       alloc_data;
  logic [15:0]      alloc_wide;
  logic [3:0]       lf_m1;

  // Execute-side datapath.
  logic [3:0]       sh;
  logic [7:0]       bmask;
  logic [15:0]      pop_hi_wide, pop_lo_wide, keep_wide;
  logic [7:0]       rmw_data;
  logic             rbit_d;
  logic [7:0]       rbyte_d;
  logic [HW-1:0]    held_new;

  assign act      = pbs_pkg::action_e'(action_i);
  assign accept   = start_i && (state_q == pbs_pkg::S_IDLE);
  assign aligned  = (lf_q >= pbs_pkg::FILL_FULL);
  assign cc_m1    = cc_q - CW'(1);
  assign cc_m2    = cc_q - CW'(2);
  assign held     = (cc_q == '0) ? '0 : HW'({cc_m1, 3'b000}) + HW'(lf_q);
  assign idx_ext  = HW'(bit_index_i);
  assign idx_addr = idx_ext[AW+2:3];
  assign lf_m1    = lf_q - 4'd1;

  // Aligned pushes start a fresh chunk; unaligned byte pushes spill their low bits into it.
  assign alloc_wide = {8'h00, byte_value_i} << (4'd8 - lf_q);

  // Decode the operation, check limits and update the bookkeeping at accept time.
  always_comb begin
    cc_d       = cc_q;
    lf_d       = lf_q;
    stat_d     = pbs_pkg::ST_OK;
    pos_d      = lf_q[2:0];
    rmw_d      = 1'b0;
    rmw_addr_d = cc_m1[AW-1:0];
    alloc_we   = 1'b0;
    alloc_data = alloc_wide[7:0];
    raddr_a    = cc_m1[AW-1:0];
    raddr_b    = cc_m2[AW-1:0];
    unique case (act)
      pbs_pkg::ACT_PUSH_BIT: begin
        if (aligned && cc_q >= CW'(CAPACITY_BYTES)) begin
          stat_d = pbs_pkg::ST_FULL;
        end else if (aligned) begin
          alloc_we   = 1'b1;
          alloc_data = {bit_value_i, 7'b0000000};
          cc_d       = cc_q + CW'(1);
          lf_d       = 4'd1;
        end else begin
          rmw_d = 1'b1;
          lf_d  = lf_q + 4'd1;
        end
      end
      pbs_pkg::ACT_POP_BIT: begin
        if (cc_q == '0) begin
          stat_d = pbs_pkg::ST_EMPTY;
        end else begin
          pos_d = lf_m1[2:0];
          rmw_d = 1'b1;
          if (lf_m1 == 4'd0) begin
            cc_d = cc_m1;
            lf_d = pbs_pkg::FILL_FULL;
          end else begin
            lf_d = lf_m1;
          end
        end
      end
      pbs_pkg::ACT_PUSH_BYTE: begin
        if (cc_q >= CW'(CAPACITY_BYTES)) begin
          stat_d = pbs_pkg::ST_FULL;
        end else begin
          alloc_we = 1'b1;
          rmw_d    = !aligned;
          cc_d     = cc_q + CW'(1);
        end
      end
      pbs_pkg::ACT_POP_BYTE: begin
        if (aligned && cc_q == '0) begin
          stat_d = pbs_pkg::ST_EMPTY;
        end else if (!aligned && cc_q < CW'(2)) begin
          stat_d = pbs_pkg::ST_EMPTY;
        end else begin
          rmw_d      = !aligned;
          rmw_addr_d = cc_m2[AW-1:0];
          cc_d       = cc_m1;
        end
      end
      pbs_pkg::ACT_READ_BIT: begin
        raddr_a = idx_addr;
        pos_d   = bit_index_i[2:0];
        if (idx_ext >= held) begin
          stat_d = pbs_pkg::ST_RANGE;
        end
      end
      pbs_pkg::ACT_WRITE_BIT: begin
        raddr_a    = idx_addr;
        pos_d      = bit_index_i[2:0];
        rmw_addr_d = idx_addr;
        if (idx_ext >= held) begin
          stat_d = pbs_pkg::ST_RANGE;
        end else begin
          rmw_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Execute-side shifts: old fill selects how the popped byte straddles two chunks.
  assign sh          = 4'd8 - olf_q;
  assign bmask       = 8'h80 >> pos_q;
  assign pop_hi_wide = {8'h00, rd_a_q} >> sh;
  assign pop_lo_wide = {8'h00, rd_b_q} << olf_q;
  assign keep_wide   = 16'h00FF << sh;

  // Merge the read chunk with the operation and pick the result values.
  always_comb begin
    rmw_data = rd_a_q;
    rbit_d   = 1'b0;
    rbyte_d  = 8'h00;
    unique case (op_q)
      pbs_pkg::ACT_PUSH_BIT: begin
        rmw_data = bitv_q ? (rd_a_q | bmask) : rd_a_q;
      end
      pbs_pkg::ACT_POP_BIT: begin
        rmw_data = rd_a_q & ~bmask;
        rbit_d   = |(rd_a_q & bmask);
      end
      pbs_pkg::ACT_PUSH_BYTE: begin
        rmw_data = rd_a_q | (bytev_q >> olf_q);
      end
      pbs_pkg::ACT_POP_BYTE: begin
        rmw_data = rd_b_q & keep_wide[7:0];
        rbyte_d  = pop_hi_wide[7:0] | pop_lo_wide[7:0];
      end
      pbs_pkg::ACT_READ_BIT: begin
        rbit_d = |(rd_a_q & bmask);
      end
      pbs_pkg::ACT_WRITE_BIT: begin
        rmw_data = bitv_q ? (rd_a_q | bmask) : (rd_a_q & ~bmask);
      end
      default: begin
      end
    endcase
    if (stat_q != pbs_pkg::ST_OK) begin
      rbit_d  = 1'b0;
      rbyte_d = 8'h00;
    end
  end

  // Write port: chunk allocation at accept, read-modify-write in the execute cycle.
  always_comb begin
    we    = 1'b0;
    waddr = cc_q[AW-1:0];
    wdata = alloc_data;
    if (accept && alloc_we) begin
      we = 1'b1;
    end else if (state_q == pbs_pkg::S_EXEC && rmw_q && stat_q == pbs_pkg::ST_OK) begin
      we    = 1'b1;
      waddr = rmw_addr_q;
      wdata = rmw_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a_q <= mem[raddr_a];
    rd_b_q <= mem[raddr_b];
  end

  // Bit count after the operation, from the already updated bookkeeping.
  assign held_new = (cc_q == '0) ? '0 : HW'({cc_m1, 3'b000}) + HW'(lf_q);

  // Sequencer: an operation is accepted in idle, then executed in the execute state before returning to idle.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pbs_pkg::S_IDLE: if (accept) state_d = pbs_pkg::S_EXEC;
      pbs_pkg::S_EXEC: state_d = pbs_pkg::S_IDLE;
      default:         state_d = pbs_pkg::S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pbs_pkg::S_IDLE;
      cc_q    <= '0;
      lf_q    <= pbs_pkg::FILL_FULL;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == pbs_pkg::S_EXEC);
      if (accept) begin
        cc_q <= cc_d;
        lf_q <= lf_d;
      end
    end
  end

  // Operation context and result payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q       <= act;
      stat_q     <= stat_d;
      bitv_q     <= bit_value_i;
      bytev_q    <= byte_value_i;
      olf_q      <= lf_q;
      pos_q      <= pos_d;
      rmw_q      <= rmw_d;
      rmw_addr_q <= rmw_addr_d;
    end
    if (state_q == pbs_pkg::S_EXEC) begin
      rbit_q  <= rbit_d;
      rbyte_q <= rbyte_d;
      rstat_q <= stat_q;
      count_q <= held_new[12:0];
    end
  end

  assign busy_o      = (state_q != pbs_pkg::S_IDLE);
  assign done_o      = done_q;
  assign read_bit_o  = rbit_q;
  assign read_byte_o = rbyte_q;
  assign status_o    = rstat_q;
  assign bit_count_o = count_q;

endmodule

`default_nettype wire
